// ===== design/npps_pkg.sv =====
package npps_pkg;

    localparam int ARR_W  = 16;
    localparam int BUR_W  = 16;
    localparam int PRI_W  = 8;
    localparam int PID_W  = 5;
    localparam int CT_W   = 21;
    localparam int TA_W   = 20;
    localparam int WT_W   = 20;
    localparam int AVG_W  = 28;
    localparam int TW_W   = 24;
    localparam int TT_W   = 25;
    localparam int FRAC_W = 8;
    localparam int DIV_W  = TT_W + FRAC_W;

    typedef struct packed {
        logic [ARR_W-1:0] arrive_at;
        logic [BUR_W-1:0] run_len;
        logic [PRI_W-1:0] priority_req;
        logic             last_process;
    } job_t;

    typedef struct packed {
        logic [PID_W-1:0] process_id;
        logic [CT_W-1:0]  finish_at;
        logic [TA_W-1:0]  turn_len;
        logic [WT_W-1:0]  wait_len;
        logic [AVG_W-1:0] avg_waiting;
        logic [AVG_W-1:0] avg_turnaround;
        logic             last_result;
    } result_t;

    typedef struct packed {
        logic [ARR_W-1:0] arrival;
        logic [BUR_W-1:0] burst;
        logic [PRI_W-1:0] prio;
    } entry_t;

    typedef enum logic [10:0] {
        S_LOAD   = 11'b000_0000_0001,
        S_SCAN_E = 11'b000_0000_0010,
        S_JUMP   = 11'b000_0000_0100,
        S_SCAN_P = 11'b000_0000_1000,
        S_ADV    = 11'b000_0001_0000,
        S_TA     = 11'b000_0010_0000,
        S_WT     = 11'b000_0100_0000,
        S_SUM    = 11'b000_1000_0000,
        S_DIV_W  = 11'b001_0000_0000,
        S_DIV_T  = 11'b010_0000_0000,
        S_EMIT   = 11'b100_0000_0000
    } state_t;

endpackage

// ===== design/nonpreemptive_priority_scheduler_core.sv =====
// channel  | handshake                  | payload
// job      | job_valid / job_stall      | job    (npps_pkg::job_t)
// result   | result_valid / result_stall| result (npps_pkg::result_t)
//
// a job item is taken whenever job_valid is high while loading; the item marked last, or the one
// that fills MAX_JOBS, starts the schedule and job_stall stays high until the last
// result is registered. each dispatch runs two scans over the single read port of the
// job memory; the final result also waits for the bit-serial divider that forms both
// averages. rst_n clears control state asynchronously; the job memory is not cleared.
// result_stall holds the output register; a dispatch that ends while it is held
// waits to emit.
module nonpreemptive_priority_scheduler_core #(
    parameter int MAX_JOBS = 16
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              job_valid,
    output logic              job_stall,
    input  npps_pkg::job_t    job,
    output logic              result_valid,
    input  logic              result_stall,
    output npps_pkg::result_t result
);

    import npps_pkg::*;

    localparam int IW  = (MAX_JOBS > 1) ? $clog2(MAX_JOBS) : 1;
    localparam int CW  = $clog2(MAX_JOBS + 1);
    localparam int DCW = $clog2(DIV_W);
    localparam logic [CW-1:0]  JOBS_MAX = CW'(MAX_JOBS);
    localparam logic [DCW-1:0] DIV_LAST = DCW'(DIV_W - 1);

    state_t              state_reg, state_next;
    logic [CW-1:0]       count_reg, count_next;
    logic [CW-1:0]       disp_reg, disp_next;
    logic [CW-1:0]       scan_reg, scan_next;
    logic                rdv_reg, rdv_next;
    logic [IW-1:0]       rdi_reg, rdi_next;
    logic [MAX_JOBS-1:0] done_reg, done_next;
    logic [CT_W-1:0]     cur_reg, cur_next;
    logic [TW_W-1:0]     tw_reg, tw_next;
    logic [TT_W-1:0]     tt_reg, tt_next;
    logic                any_reg, any_next;
    logic                found_reg, found_next;
    logic                last_reg, last_next;
    logic [DCW-1:0]      dcnt_reg, dcnt_next;
    logic                result_valid_reg, result_valid_next;

    logic [ARR_W-1:0]    earliest_reg, earliest_next;
    logic [IW-1:0]       best_id_reg, best_id_next;
    logic [ARR_W-1:0]    best_arr_reg, best_arr_next;
    logic [BUR_W-1:0]    best_burst_reg, best_burst_next;
    logic [PRI_W-1:0]    best_prio_reg, best_prio_next;
    logic [TA_W-1:0]     ta_reg, ta_next;
    logic [WT_W-1:0]     wt_reg, wt_next;
    logic [CW-1:0]       rem_reg, rem_next;
    logic [DIV_W-1:0]    dq_reg, dq_next;
    logic [AVG_W-1:0]    avg_w_reg, avg_w_next;
    logic [AVG_W-1:0]    avg_t_reg, avg_t_next;
    result_t             result_reg, result_next;

    entry_t              wr_entry;
    entry_t              rd_entry;
    logic                wr_en;
    logic                rd_en;
    logic                scanning;
    logic                scan_done;
    logic                cand_done;
    logic [CW:0]         trial;
    logic                div_ge;
    logic [CW-1:0]       div_rem;
    logic [DIV_W-1:0]    div_q;
    logic [31:0]         pid_full;

    assign wr_en    = (state_reg == S_LOAD) && job_valid;
    assign wr_entry = '{arrival: job.arrive_at, burst: job.run_len,
                        prio: job.priority_req};
    assign scanning = (state_reg == S_SCAN_E) || (state_reg == S_SCAN_P);
    assign rd_en    = scanning && (scan_reg != count_reg);
    assign scan_done = (scan_reg == count_reg) && !rdv_reg;
    assign cand_done = done_reg[rdi_reg];

    npps_ram #(
        .WIDTH ($bits(entry_t)),
        .DEPTH (MAX_JOBS)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (count_reg[IW-1:0]),
        .wr_data (wr_entry),
        .rd_en   (rd_en),
        .rd_addr (scan_reg[IW-1:0]),
        .rd_data (rd_entry)
    );

    // restoring divider step, one quotient bit per cycle
    assign trial   = {rem_reg, dq_reg[DIV_W-1]};
    assign div_ge  = trial >= {1'b0, count_reg};
    assign div_rem = div_ge ? CW'(trial - {1'b0, count_reg}) : trial[CW-1:0];
    assign div_q   = {dq_reg[DIV_W-2:0], div_ge};

    assign pid_full = 32'(best_id_reg) + 32'd1;

    always_comb
    begin
        state_next        = state_reg;
        count_next        = count_reg;
        disp_next         = disp_reg;
        scan_next         = scan_reg;
        rdv_next          = rd_en;
        rdi_next          = scan_reg[IW-1:0];
        done_next         = done_reg;
        cur_next          = cur_reg;
        tw_next           = tw_reg;
        tt_next           = tt_reg;
        any_next          = any_reg;
        found_next        = found_reg;
        last_next         = last_reg;
        dcnt_next         = dcnt_reg;
        result_valid_next = result_valid_reg;
        earliest_next     = earliest_reg;
        best_id_next      = best_id_reg;
        best_arr_next     = best_arr_reg;
        best_burst_next   = best_burst_reg;
        best_prio_next    = best_prio_reg;
        ta_next           = ta_reg;
        wt_next           = wt_reg;
        rem_next          = rem_reg;
        dq_next           = dq_reg;
        avg_w_next        = avg_w_reg;
        avg_t_next        = avg_t_reg;
        result_next       = result_reg;

        if (result_valid_reg && !result_stall)
        begin
            result_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_LOAD:
            begin
                if (job_valid)
                begin
                    count_next = count_reg + CW'(1);
                    done_next[count_reg[IW-1:0]] = 1'b0;
                    if (job.last_process || (count_reg + CW'(1) == JOBS_MAX))
                    begin
                        state_next = S_SCAN_E;
                        scan_next  = '0;
                        any_next   = 1'b0;
                        disp_next  = '0;
                    end
                end
            end
            S_SCAN_E:
            begin
                if (rd_en)
                begin
                    scan_next = scan_reg + CW'(1);
                end
                if (rdv_reg && !cand_done && (!any_reg || rd_entry.arrival < earliest_reg))
                begin
                    earliest_next = rd_entry.arrival;
                    any_next      = 1'b1;
                end
                if (scan_done)
                begin
                    state_next = S_JUMP;
                end
            end
            S_JUMP:
            begin
                if (CT_W'(earliest_reg) > cur_reg)
                begin
                    cur_next = CT_W'(earliest_reg);
                end
                scan_next  = '0;
                found_next = 1'b0;
                state_next = S_SCAN_P;
            end
            S_SCAN_P:
            begin
                if (rd_en)
                begin
                    scan_next = scan_reg + CW'(1);
                end
                if (rdv_reg && !cand_done && (CT_W'(rd_entry.arrival) <= cur_reg)
                    && (!found_reg || rd_entry.prio < best_prio_reg))
                begin
                    best_id_next    = rdi_reg;
                    best_arr_next   = rd_entry.arrival;
                    best_burst_next = rd_entry.burst;
                    best_prio_next  = rd_entry.prio;
                    found_next      = 1'b1;
                end
                if (scan_done)
                begin
                    state_next = S_ADV;
                end
            end
            S_ADV:
            begin
                cur_next = cur_reg + CT_W'(best_burst_reg);
                done_next[best_id_reg] = 1'b1;
                state_next = S_TA;
            end
            S_TA:
            begin
                ta_next    = TA_W'(cur_reg - CT_W'(best_arr_reg));
                state_next = S_WT;
            end
            S_WT:
            begin
                wt_next    = ta_reg - TA_W'(best_burst_reg);
                tt_next    = tt_reg + TT_W'(ta_reg);
                disp_next  = disp_reg + CW'(1);
                last_next  = (disp_reg + CW'(1)) == count_reg;
                state_next = S_SUM;
            end
            S_SUM:
            begin
                tw_next = tw_reg + TW_W'(wt_reg);
                if (last_reg)
                begin
                    dq_next    = DIV_W'({tw_next, {FRAC_W{1'b0}}});
                    rem_next   = '0;
                    dcnt_next  = '0;
                    state_next = S_DIV_W;
                end
                else
                begin
                    state_next = S_EMIT;
                end
            end
            S_DIV_W:
            begin
                rem_next  = div_rem;
                dq_next   = div_q;
                dcnt_next = dcnt_reg + DCW'(1);
                if (dcnt_reg == DIV_LAST)
                begin
                    avg_w_next = div_q[AVG_W-1:0];
                    dq_next    = {tt_reg, {FRAC_W{1'b0}}};
                    rem_next   = '0;
                    dcnt_next  = '0;
                    state_next = S_DIV_T;
                end
            end
            S_DIV_T:
            begin
                rem_next  = div_rem;
                dq_next   = div_q;
                dcnt_next = dcnt_reg + DCW'(1);
                if (dcnt_reg == DIV_LAST)
                begin
                    avg_t_next = div_q[AVG_W-1:0];
                    state_next = S_EMIT;
                end
            end
            S_EMIT:
            begin
                if (!result_valid_reg || !result_stall)
                begin
                    result_valid_next          = 1'b1;
                    result_next.process_id     = pid_full[PID_W-1:0];
                    result_next.finish_at      = cur_reg;
                    result_next.turn_len       = ta_reg;
                    result_next.wait_len       = wt_reg;
                    result_next.avg_waiting    = last_reg ? avg_w_reg : '0;
                    result_next.avg_turnaround = last_reg ? avg_t_reg : '0;
                    result_next.last_result    = last_reg;
                    if (last_reg)
                    begin
                        done_next  = '0;
                        count_next = '0;
                        cur_next   = '0;
                        tw_next    = '0;
                        tt_next    = '0;
                        state_next = S_LOAD;
                    end
                    else
                    begin
                        scan_next  = '0;
                        any_next   = 1'b0;
                        state_next = S_SCAN_E;
                    end
                end
            end
            default:
            begin
                state_next = S_LOAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_LOAD;
            count_reg        <= '0;
            disp_reg         <= '0;
            scan_reg         <= '0;
            rdv_reg          <= 1'b0;
            done_reg         <= '0;
            cur_reg          <= '0;
            tw_reg           <= '0;
            tt_reg           <= '0;
            any_reg          <= 1'b0;
            found_reg        <= 1'b0;
            last_reg         <= 1'b0;
            dcnt_reg         <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            count_reg        <= count_next;
            disp_reg         <= disp_next;
            scan_reg         <= scan_next;
            rdv_reg          <= rdv_next;
            done_reg         <= done_next;
            cur_reg          <= cur_next;
            tw_reg           <= tw_next;
            tt_reg           <= tt_next;
            any_reg          <= any_next;
            found_reg        <= found_next;
            last_reg         <= last_next;
            dcnt_reg         <= dcnt_next;
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rdi_reg        <= rdi_next;
        earliest_reg   <= earliest_next;
        best_id_reg    <= best_id_next;
        best_arr_reg   <= best_arr_next;
        best_burst_reg <= best_burst_next;
        best_prio_reg  <= best_prio_next;
        ta_reg         <= ta_next;
        wt_reg         <= wt_next;
        rem_reg        <= rem_next;
        dq_reg         <= dq_next;
        avg_w_reg      <= avg_w_next;
        avg_t_reg      <= avg_t_next;
        result_reg     <= result_next;
    end

    assign job_stall    = (state_reg != S_LOAD);
    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule

// ===== design/npps_ram.sv =====
module npps_ram #(
    parameter int WIDTH = 40,
    parameter int DEPTH = 16
) (
    input  logic                                        clk,
    input  logic                                        wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                            wr_data,
    input  logic                                        rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                            rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ===== design/npps_checker.sv =====
module npps_checker (
    input logic              clk,
    input logic              rst_n,
    input logic              job_valid,
    input logic              job_stall,
    input npps_pkg::job_t    job,
    input logic              result_valid,
    input logic              result_stall,
    input npps_pkg::result_t result
);

    import npps_pkg::*;

    // a held result keeps its value
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid && $stable(result))
        else $error("result changed while stalled");

    // a last job starts scheduling, no further job is taken
    a_last_job_stalls: assert property (@(posedge clk) disable iff (!rst_n)
        job_valid && !job_stall && job.last_process |=> job_stall)
        else $error("job taken right after a last job");

    // averages only on the final result
    a_avg_only_last: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result.last_result
        |-> result.avg_waiting == '0 && result.avg_turnaround == '0)
        else $error("average shown on a non-final result");

    // a non-final result means the schedule is still running, input stays stalled
    a_mid_schedule_stall: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result.last_result |-> job_stall)
        else $error("job accepted in the middle of a schedule");

endmodule

bind nonpreemptive_priority_scheduler_core npps_checker u_npps_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .job_valid    (job_valid),
    .job_stall    (job_stall),
    .job          (job),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
);
